// ----- rtl/dttfp_pkg.sv -----
// Shared types and constants for the decimal text to fixed point converter.
// Used by dttfp_ctrl, dttfp_dp and the top level. No dependencies.
`default_nettype none

package dttfp_pkg;

    localparam int INT_W    = 27;
    localparam int OUT_W    = 32;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 3;
    localparam int QUO_W    = 4;
    localparam int BIT_W    = 2;

    localparam logic [INT_W-1:0]  INT_SAT    = '1;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam int SHIFT_FINE   = 4;
    localparam int SHIFT_COARSE = 1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             accept_char;
        logic             start_div;
        logic             div_step;
        logic [BIT_W-1:0] div_bit;
        logic             load_out;
    } dttfp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_term;
    } dttfp_stat_t;

    function automatic logic [31:0] pow10(input logic [CNT_W-1:0] k);
        logic [31:0] p;
        unique case (k)
            3'd0:    p = 32'd1;
            3'd1:    p = 32'd10;
            3'd2:    p = 32'd100;
            3'd3:    p = 32'd1000;
            3'd4:    p = 32'd10000;
            3'd5:    p = 32'd100000;
            3'd6:    p = 32'd1000000;
            default: p = 32'd10000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dttfp_ctrl.sv -----
// Controller for the decimal text to fixed point converter: handshakes,
// divide sequencing and output register valid. Depends on dttfp_pkg.
`default_nettype none

module dttfp_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  dttfp_pkg::dttfp_stat_t  stat,
    output dttfp_pkg::dttfp_cmd_t   cmd
);
    import dttfp_pkg::*;

    typedef enum logic [2:0] {
        ST_ACCEPT = 3'b001,
        ST_DIV    = 3'b010,
        ST_LOAD   = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept, out_free;

    assign s_ready  = (state_reg == ST_ACCEPT);
    assign m_valid  = m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        bit_next        = bit_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd.accept_char = 1'b0;
        cmd.start_div   = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.div_bit     = bit_reg;
        cmd.load_out    = 1'b0;
        unique case (state_reg)
            ST_ACCEPT: begin
                if (accept) begin
                    if (stat.is_term) begin
                        cmd.start_div = 1'b1;
                        bit_next      = '1;
                        state_next    = ST_DIV;
                    end else begin
                        cmd.accept_char = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_ACCEPT;
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCEPT;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dttfp_dp.sv -----
// Datapath for the decimal text to fixed point converter: character decode,
// accumulators, restoring fraction divider, output register. Uses dttfp_pkg.
`default_nettype none

module dttfp_dp #(
    parameter int MAX_FRAC_DIGITS = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [dttfp_pkg::CHAR_W-1:0]  s_char_code,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    input  dttfp_pkg::dttfp_cmd_t              cmd,
    output dttfp_pkg::dttfp_stat_t             stat,
    output logic signed [dttfp_pkg::OUT_W-1:0] m_value,
    output logic                               m_had_digits
);
    import dttfp_pkg::*;

    localparam int FW = $clog2(10 ** MAX_FRAC_DIGITS);       // fraction accumulator
    localparam int DW = $clog2(10 ** MAX_FRAC_DIGITS + 1);   // largest divisor
    localparam int W  = ((FW > DW) ? FW : DW) + QUO_W;       // divider width

    // number state
    logic [INT_W-1:0] int_reg, int_next;
    logic [FW-1:0]    frac_reg, frac_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_frac_reg, in_frac_next;
    logic             neg_reg, neg_next;
    logic             start_reg, start_next;
    logic             seen_reg, seen_next;
    logic             coarse_reg;

    // divider
    logic [W-1:0]     rem_reg, rem_next;
    logic [DW-1:0]    div_reg, div_next;
    logic [QUO_W-1:0] q_reg, q_next;

    // output
    logic signed [OUT_W-1:0] value_reg, value_next;
    logic                    had_reg;

    logic             is_digit, is_minus, is_point;
    logic [3:0]       digit;
    logic [INT_W+3:0] int_prod;
    logic [FW+3:0]    frac_prod;
    logic [W-1:0]     trial;
    logic [OUT_W-1:0] mag;

    assign is_digit = (s_char_code >= CHAR_ZERO) && (s_char_code <= CHAR_NINE);
    assign is_minus = (s_char_code == CHAR_MINUS) && start_reg;
    assign is_point = (s_char_code == CHAR_POINT);
    assign digit    = 4'(s_char_code - CHAR_ZERO);
    assign stat.is_term = !(is_digit || is_minus || is_point);

    assign int_prod  = (INT_W+4)'({int_reg, 3'b000}) + (INT_W+4)'({int_reg, 1'b0})
                     + (INT_W+4)'(digit);
    assign frac_prod = (FW+4)'({frac_reg, 3'b000}) + (FW+4)'({frac_reg, 1'b0})
                     + (FW+4)'(digit);
    assign trial     = W'(div_reg) << cmd.div_bit;
    assign mag       = (coarse_reg ? (OUT_W'(int_reg) << SHIFT_COARSE)
                                   : (OUT_W'(int_reg) << SHIFT_FINE))
                     + OUT_W'(q_reg);

    always_comb begin
        int_next     = int_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        in_frac_next = in_frac_reg;
        neg_next     = neg_reg;
        start_next   = start_reg;
        seen_next    = seen_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        q_next       = q_reg;
        value_next   = value_reg;
        if (cmd.accept_char) begin
            start_next = 1'b0;
            priority if (is_minus) begin
                neg_next = 1'b1;
            end else if (is_digit) begin
                seen_next = 1'b1;
                if (in_frac_reg) begin
                    if (cnt_reg < CNT_W'(MAX_FRAC_DIGITS)) begin
                        frac_next = FW'(frac_prod);
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end else begin
                    int_next = (int_prod > (INT_W+4)'(INT_SAT)) ? INT_SAT
                                                                : INT_W'(int_prod);
                end
            end else begin
                in_frac_next = 1'b1;
            end
        end
        if (cmd.start_div) begin
            rem_next = coarse_reg ? (W'(frac_reg) << SHIFT_COARSE)
                                  : (W'(frac_reg) << SHIFT_FINE);
            div_next = DW'(pow10(cnt_reg));
            q_next   = '0;
        end
        if (cmd.div_step && (rem_reg >= trial)) begin
            rem_next            = rem_reg - trial;
            q_next[cmd.div_bit] = 1'b1;
        end
        if (cmd.load_out) begin
            value_next   = neg_reg ? -$signed(mag) : $signed(mag);
            int_next     = '0;
            frac_next    = '0;
            cnt_next     = '0;
            in_frac_next = 1'b0;
            neg_next     = 1'b0;
            start_next   = 1'b1;
            seen_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_reg     <= '0;
            frac_reg    <= '0;
            cnt_reg     <= '0;
            in_frac_reg <= 1'b0;
            neg_reg     <= 1'b0;
            start_reg   <= 1'b1;
            seen_reg    <= 1'b0;
            coarse_reg  <= 1'b0;
        end else begin
            int_reg     <= int_next;
            frac_reg    <= frac_next;
            cnt_reg     <= cnt_next;
            in_frac_reg <= in_frac_next;
            neg_reg     <= neg_next;
            start_reg   <= start_next;
            seen_reg    <= seen_next;
            if (cfg_wr_en) begin
                coarse_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        q_reg     <= q_next;
        value_reg <= value_next;
        if (cmd.load_out) begin
            had_reg <= seen_reg;
        end
    end

    assign m_value      = value_reg;
    assign m_had_digits = had_reg;

endmodule

`default_nettype wire

// ----- rtl/decimal_text_to_fixed_point.sv -----
// Top level of the decimal text to fixed point converter.
// Instantiates dttfp_ctrl and dttfp_dp; uses dttfp_pkg.
`default_nettype none

// Converts decimal text, one character per transaction, into a signed
// fixed-point value with 4 fraction bits (1 bit when coarse_mode is set).
// Digits, a point and a leading minus are accepted and produce no
// result. Any other character ends the number: the fraction is divided by
// 10^k in a 4-step restoring divider, one quotient bit per cycle, then the
// result is loaded into the output register, so s_ready stays low from a
// taken terminating character through the divide and the load, plus any
// time the previous result still waits on m_ready. The integer part
// saturates at 2^27-1. coarse_mode is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while idle, as the block does not enforce it.
module decimal_text_to_fixed_point #(
    parameter int MAX_FRAC_DIGITS = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dttfp_pkg::CHAR_W-1:0]  s_char_code,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [dttfp_pkg::OUT_W-1:0] m_value,
    output logic                               m_had_digits,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data
);
    import dttfp_pkg::*;

    dttfp_cmd_t  cmd;
    dttfp_stat_t stat;

    dttfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dttfp_dp #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_char_code  (s_char_code),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .stat         (stat),
        .m_value      (m_value),
        .m_had_digits (m_had_digits)
    );

endmodule

`default_nettype wire
